// ===== hw/rtl/esc_codec_pkg.sv =====
package esc_codec_pkg;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_N   = 8'h6E;
	localparam logic [7:0] CH_T   = 8'h74;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7E;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} codec_mode_t;

	typedef logic [1:0] beat_cnt_t;

	typedef struct packed {
		beat_cnt_t  cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} xlate_t;

endpackage

// ===== hw/rtl/esc_byte_if.sv =====
interface esc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hw/rtl/esc_result_if.sv =====
interface esc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hw/rtl/esc_codec_xlate.sv =====
module esc_codec_xlate
	import esc_codec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  codec_mode_t mode,
	input  logic [7:0]  in_byte,
	input  logic        fire,
	output xlate_t      xl
);

	logic pending_q;
	logic pending_d;
	logic [7:0] esc;
	logic       esc_hit;

	always_comb begin
		xl        = '{cnt: 2'd0, b0: in_byte, b1: in_byte};
		pending_d = pending_q;
		esc       = CH_NUL;
		esc_hit   = 1'b0;
		if (in_byte == CH_NUL) begin
			xl.cnt    = 2'd1;
			xl.b0     = CH_NUL;
			pending_d = 1'b0;
		end else if (mode == MODE_ENCODE) begin
			unique case (in_byte)
				CH_NL:   begin esc = CH_N;   esc_hit = 1'b1; end
				CH_TAB:  begin esc = CH_T;   esc_hit = 1'b1; end
				CH_CR:   begin esc = CH_R;   esc_hit = 1'b1; end
				CH_BSL:  begin esc = CH_BSL; esc_hit = 1'b1; end
				default: begin esc = CH_NUL; esc_hit = 1'b0; end
			endcase
			if (esc_hit) begin
				xl.cnt = 2'd2;
				xl.b0  = CH_BSL;
				xl.b1  = esc;
			end else if (in_byte >= CH_PRINT_LO && in_byte <= CH_PRINT_HI) begin
				xl.cnt = 2'd1;
			end
		end else if (pending_q) begin
			pending_d = 1'b0;
			unique case (in_byte)
				CH_N:    begin esc = CH_NL;  esc_hit = 1'b1; end
				CH_T:    begin esc = CH_TAB; esc_hit = 1'b1; end
				CH_R:    begin esc = CH_CR;  esc_hit = 1'b1; end
				CH_BSL:  begin esc = CH_BSL; esc_hit = 1'b1; end
				default: begin esc = CH_NUL; esc_hit = 1'b0; end
			endcase
			if (esc_hit) begin
				xl.cnt = 2'd1;
				xl.b0  = esc;
			end
		end else if (in_byte == CH_BSL) begin
			pending_d = 1'b1;
		end else begin
			xl.cnt = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (fire) begin
			pending_q <= pending_d;
		end
	end

endmodule

// ===== hw/rtl/esc_codec_outbuf.sv =====
module esc_codec_outbuf
	import esc_codec_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  xlate_t xl,
	input  logic   load,
	output logic   can_load,
	esc_result_if.source result
);

	beat_cnt_t  cnt_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	logic       pop;

	assign pop                = result.valid && result.ready;
	assign can_load           = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign result.valid       = cnt_q != 2'd0;
	assign result.out_byte    = b0_q;
	assign result.last_of_run = cnt_q == 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= xl.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			b0_q <= xl.b0;
			b1_q <= xl.b1;
		end else if (pop) begin
			b0_q <= b1_q;
		end
	end

endmodule

// ===== hw/rtl/escape_sequence_codec_unit.sv =====
// Backslash escape codec. An accepted byte is registered, translated combinationally
// and loaded into a two-byte result buffer that drains one beat per cycle while the
// receiver is ready. A byte that yields at most one result (pass-through, drop,
// decode, terminator) lets the next byte load as its beat, if any, drains; an
// encoded newline, tab, carriage return or backslash yields two beats and holds the
// next byte until both drain. A byte of 0 always yields a 0 terminator beat and
// clears any pending escape. Write cfg_wdata (0 encode, 1 decode) only while idle.
module escape_sequence_codec_unit
	import esc_codec_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	esc_byte_if.sink     feed,
	esc_result_if.source result
);

	codec_mode_t codec_mode_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        can_load;
	logic        fire;
	xlate_t      xl;

	assign fire       = valid_s1 && can_load;
	assign feed.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= MODE_ENCODE;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				codec_mode_q <= codec_mode_t'(cfg_wdata);
			end
			if (feed.ready) begin
				valid_s1 <= feed.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed.ready && feed.valid) begin
			byte_s1 <= feed.in_byte;
		end
	end

	esc_codec_xlate u_xlate (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (codec_mode_q),
		.in_byte (byte_s1),
		.fire    (fire),
		.xl      (xl)
	);

	esc_codec_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.xl       (xl),
		.load     (fire),
		.can_load (can_load),
		.result   (result)
	);

endmodule

// ===== hw/rtl/esc_codec_chk.sv =====
module esc_codec_chk
	import esc_codec_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_byte)
			&& $stable(last_of_run))
		else $error("stalled result beat changed");

	a_first_is_bsl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run |-> out_byte == CH_BSL)
		else $error("first beat of a pair is not a backslash");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last_of_run |=> result_valid && last_of_run)
		else $error("second beat of a pair missing");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_byte == CH_NUL |-> last_of_run)
		else $error("terminator beat not marked last");

endmodule

bind escape_sequence_codec_unit esc_codec_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.out_byte     (result.out_byte),
	.last_of_run  (result.last_of_run)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import esc_codec_pkg::*;

	localparam int STALL_PCT = 27;
	localparam int WATCHDOG  = 2000;
	localparam int PHASE_LEN = 115;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} out_char_t;

	class escape_tracker;
		codec_mode_t mode;
		bit          esc_open;
		out_char_t   due[$];
		int          errors;
		int          bytes_in;
		int          chars_out;
		int          terminators;

		function new();
			mode = MODE_ENCODE;
			esc_open = 0;
			errors = 0;
			bytes_in = 0;
			chars_out = 0;
			terminators = 0;
		endfunction

		function void push(logic [7:0] c, logic last);
			out_char_t e;
			e.ch = c;
			e.last = last;
			due.push_back(e);
		endfunction

		function void take_source_byte(logic [7:0] b);
			logic [7:0] esc;
			esc = CH_NUL;
			bytes_in++;
			if (b == CH_NUL) begin
				esc_open = 0;
				terminators++;
				push(CH_NUL, 1'b1);
				return;
			end
			if (mode == MODE_ENCODE) begin
				case (b)
					CH_NL: esc = CH_N;
					CH_TAB: esc = CH_T;
					CH_CR: esc = CH_R;
					CH_BSL: esc = CH_BSL;
					default: esc = CH_NUL;
				endcase
				if (esc != CH_NUL) begin
					push(CH_BSL, 1'b0);
					push(esc, 1'b1);
				end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
					push(b, 1'b1);
				end
				return;
			end
			if (esc_open) begin
				esc_open = 0;
				case (b)
					CH_N: esc = CH_NL;
					CH_T: esc = CH_TAB;
					CH_R: esc = CH_CR;
					CH_BSL: esc = CH_BSL;
					default: esc = CH_NUL;
				endcase
				if (esc != CH_NUL)
					push(esc, 1'b1);
				return;
			end
			if (b == CH_BSL)
				esc_open = 1;
			else
				push(b, 1'b1);
		endfunction

		function void match_output_byte(logic [7:0] c, logic last);
			out_char_t e;
			if (due.size() == 0) begin
				$error("unexpected result beat: out_byte %h last_of_run %b", c, last);
				errors++;
				return;
			end
			e = due.pop_front();
			chars_out++;
			if (c !== e.ch) begin
				$error("out_byte: expected %h, got %h", e.ch, c);
				errors++;
			end
			if (last !== e.last) begin
				$error("last_of_run: expected %b, got %b", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	bit   calm;
	int   quiet_cycles;

	escape_tracker track = new();

	logic [7:0] enc_probe [11] = '{CH_NL, CH_TAB, CH_CR, CH_BSL, CH_PRINT_LO, CH_PRINT_HI,
		8'h1F, 8'h7F, 8'h80, 8'hFF, CH_NUL};
	logic [7:0] dec_probe [15] = '{CH_BSL, CH_N, CH_BSL, CH_T, CH_BSL, CH_R, CH_BSL, CH_BSL,
		CH_BSL, 8'h71, CH_BSL, CH_NUL, 8'hFF, CH_NL, CH_BSL};

	esc_byte_if   feed_if();
	esc_result_if result_if();

	escape_sequence_codec_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.feed     (feed_if),
		.result   (result_if)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		result_if.ready = calm || ($urandom_range(0, 99) >= STALL_PCT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (feed_if.valid && feed_if.ready)
				track.take_source_byte(feed_if.in_byte);
			if (result_if.valid && result_if.ready)
				track.match_output_byte(result_if.out_byte, result_if.last_of_run);
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (quiet_cycles < WATCHDOG)
			@(posedge clk);
		$display("FAIL escape_sequence_codec_unit");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			feed_if.valid = 1'b0;
			@(negedge clk);
		end
		feed_if.valid = 1'b1;
		feed_if.in_byte = b;
		do
			@(posedge clk);
		while (!feed_if.ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		feed_if.valid = 1'b0;
		while (track.due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_mode(input codec_mode_t m);
		drain_results();
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we = 1'b0;
		track.mode = m;
	endtask

	function automatic logic [7:0] escape_letter();
		case ($urandom_range(0, 3))
			0: return CH_N;
			1: return CH_T;
			2: return CH_R;
			default: return CH_BSL;
		endcase
	endfunction

	function automatic logic [7:0] control_char();
		case ($urandom_range(0, 3))
			0: return CH_NL;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_BSL;
		endcase
	endfunction

	task automatic random_text(input int n, input codec_mode_t m);
		int sent;
		int r;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (m == MODE_ENCODE) begin
				if (r < 15)
					send_byte(control_char());
				else if (r < 25)
					send_byte(CH_NUL);
				else if (r < 70)
					send_byte(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
				else
					send_byte(8'($urandom_range(0, 255)));
				sent++;
			end else begin
				if (r < 25) begin
					send_byte(CH_BSL);
					if ($urandom_range(0, 9) < 8)
						send_byte(escape_letter());
					else
						send_byte(8'($urandom_range(0, 255)));
					sent += 2;
				end else begin
					if (r < 33)
						send_byte(CH_NUL);
					else if (r < 85)
						send_byte(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
					else
						send_byte(8'($urandom_range(0, 255)));
					sent++;
				end
			end
		end
	endtask

	initial begin
		codec_mode_t m;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		feed_if.valid = 1'b0;
		feed_if.in_byte = 8'h00;
		result_if.ready = 1'b0;
		quiet_cycles = 0;
		calm = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (enc_probe[i])
			send_byte(enc_probe[i]);
		write_mode(MODE_DECODE);
		foreach (dec_probe[i])
			send_byte(dec_probe[i]);
		// escape left open across a mode change
		write_mode(MODE_ENCODE);
		send_byte(CH_N);
		write_mode(MODE_DECODE);
		send_byte(CH_T);

		for (int ph = 0; ph < 8; ph++) begin
			m = (ph % 2 == 0) ? MODE_ENCODE : MODE_DECODE;
			write_mode(m);
			calm = (ph == 2);
			if (ph == 5) begin
				random_text(PHASE_LEN / 2, m);
				drain_results();
				random_text(PHASE_LEN - PHASE_LEN / 2, m);
			end else begin
				random_text(PHASE_LEN, m);
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (8) @(negedge clk);
		if (track.due.size() != 0) begin
			$error("%0d expected result beats never arrived", track.due.size());
			track.errors++;
		end
		$display("Ran %0d source bytes through encode and decode phases, mode switched mid-escape",
			track.bytes_in);
		$display("Checked %0d result beats, %0d of them string terminators",
			track.chars_out, track.terminators);
		if (track.errors == 0)
			$display("PASS escape_sequence_codec_unit");
		else
			$display("FAIL escape_sequence_codec_unit");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/esc_codec_pkg.sv
hw/rtl/esc_byte_if.sv
hw/rtl/esc_result_if.sv
hw/rtl/esc_codec_xlate.sv
hw/rtl/esc_codec_outbuf.sv
hw/rtl/escape_sequence_codec_unit.sv
hw/rtl/esc_codec_chk.sv
verif/testbench.sv
